/* rtl/bank_switch_memory_mapper_core_macros.svh */
// Assertion helpers for the mapper core. Each assumes clk and rst_n in scope.
`ifndef BANK_SWITCH_MEMORY_MAPPER_CORE_MACROS_SVH
`define BANK_SWITCH_MEMORY_MAPPER_CORE_MACROS_SVH

// Same-cycle implication.
`define BSM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bsm_pkg.sv */
`default_nettype none
package bsm_pkg;

  localparam int BANK_BYTES = 4096;
  localparam int NUM_WIN    = 10;
  localparam int WIN_IDX_W  = 4;

  localparam logic [15:0] REG_BASE  = 16'h5FF6;  // lower-window registers
  localparam logic [15:0] REG_UPPER = 16'h5FF8;  // upper-window registers
  localparam logic [15:0] REG_LAST  = 16'h5FFF;
  localparam logic [15:0] WIN_BASE  = 16'h6000;
  localparam logic [15:0] ROM_BASE  = 16'h8000;
  localparam logic [15:0] WR_LIMIT  = 16'hE000;
  localparam logic [3:0]  NIB_BASE  = 4'h6;      // nibble offset of window 0
  localparam logic [7:0]  BYTE_OPEN = 8'hFF;     // invalid register read

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_LOAD    = 2'd2,
    OP_RESTART = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CFG_DISK_MODE     = 3'd0,
    CFG_BANK_COUNT    = 3'd1,
    CFG_DEFAULT_UPPER = 3'd2,
    CFG_DEFAULT_LOWER = 3'd3,
    CFG_DEFAULT_VALID = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] bus_address;
    logic [7:0]  data_byte;
    logic [19:0] image_address;
  } in_req_t;

  typedef struct packed {
    logic       handled;
    logic [7:0] read_data;
  } out_rsp_t;

  // Bank register file update request.
  typedef struct packed {
    logic                 we;
    logic                 restart;
    logic [WIN_IDX_W-1:0] idx;
    logic [7:0]           data;
  } bank_wr_t;

endpackage
`default_nettype wire

/* rtl/bsm_ram.sv */
`default_nettype none
module bsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data holds until the next enabled read.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/bsm_bank_regs.sv */
`default_nettype none
module bsm_bank_regs (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire bsm_pkg::bank_wr_t                  bank_wr,
  input  wire logic [63:0]                        dflt_upper,
  input  wire logic [15:0]                        dflt_lower,
  input  wire logic [bsm_pkg::NUM_WIN-1:0]        dflt_valid,
  input  wire logic [bsm_pkg::WIN_IDX_W-1:0]      rd_idx,
  output logic      [8:0]                         rd_entry
);

  // bit 8 valid, bits 7..0 bank
  logic [8:0] entry_r [bsm_pkg::NUM_WIN];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < bsm_pkg::NUM_WIN; w++) begin
        entry_r[w] <= '0;
      end
    end else if (bank_wr.restart) begin
      entry_r[0] <= {dflt_valid[0], dflt_lower[7:0]};
      entry_r[1] <= {dflt_valid[1], dflt_lower[15:8]};
      for (int w = 2; w < bsm_pkg::NUM_WIN; w++) begin
        entry_r[w] <= {dflt_valid[w], dflt_upper[8*(w-2) +: 8]};
      end
    end else if (bank_wr.we && (int'(bank_wr.idx) < bsm_pkg::NUM_WIN)) begin
      entry_r[bank_wr.idx] <= {1'b1, bank_wr.data};
    end
  end

  always_comb begin
    if (int'(rd_idx) < bsm_pkg::NUM_WIN) begin
      rd_entry = entry_r[rd_idx];
    end else begin
      rd_entry = '0;
    end
  end

endmodule
`default_nettype wire

/* rtl/bank_switch_memory_mapper_core.sv */
// Bank-switching memory mapper: maps 4 KB CPU windows 0x6000-0xFFFF onto
// 4 KB banks of an image held in on-chip memory.
// Input channel (in_valid/in_stall/in_req): one request per bus read, bus
//   write, image byte load or restart. Accepted when in_valid && !in_stall.
// Result channel (out_valid/out_stall/out_rsp): exactly one result per
//   request, in order. Taken when out_valid && !out_stall.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): cfg_ready is
//   always high; write only while no request is in flight.
// Path: the decode stage and the image memory read register on acceptance,
//   then the output register, which raises out_valid; a result moves into
//   the output register only once the one held there is taken or absent.
// Throughput: one request per clock while the result side does not stall;
//   the single-port image memory and the one-entry decode stage set it.
// Stall: a stalled result holds; the decode stage then fills and in_stall
//   rises until the result is taken.
// Reset: all bank registers invalid, config at reset values. The image
//   memory is not cleared and must be loaded before it is read.
`default_nettype none
`include "bank_switch_memory_mapper_core_macros.svh"
module bank_switch_memory_mapper_core #(
  parameter int MAX_BANKS = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire bsm_pkg::in_req_t  in_req,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output bsm_pkg::out_rsp_t      out_rsp,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [63:0]       cfg_data
);

  localparam int DEPTH = MAX_BANKS * bsm_pkg::BANK_BYTES;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [8:0]  BANK_LIMIT = 9'(MAX_BANKS);
  localparam logic [20:0] LOAD_LIMIT = 21'(DEPTH);

  // Config registers
  logic        disk_mode_r;
  logic [8:0]  bank_count_r;
  logic [63:0] dflt_upper_r;
  logic [15:0] dflt_lower_r;
  logic [9:0]  dflt_valid_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_mode_r  <= 1'b0;
      bank_count_r <= 9'd1;
      dflt_upper_r <= '0;
      dflt_lower_r <= '0;
      dflt_valid_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bsm_pkg::CFG_DISK_MODE:     disk_mode_r  <= cfg_data[0];
        bsm_pkg::CFG_BANK_COUNT:    bank_count_r <= cfg_data[8:0];
        bsm_pkg::CFG_DEFAULT_UPPER: dflt_upper_r <= cfg_data;
        bsm_pkg::CFG_DEFAULT_LOWER: dflt_lower_r <= cfg_data[15:0];
        bsm_pkg::CFG_DEFAULT_VALID: dflt_valid_r <= cfg_data[9:0];
        default: ;  // unknown index ignored
      endcase
    end
  end

  // Handshake and pipeline control
  logic s1_vld_r, s1_vld_nxt;
  logic s1_handled_r, s1_handled_nxt;
  logic s1_use_ram_r, s1_use_ram_nxt;
  logic [7:0] s1_rd_r, s1_rd_nxt;
  logic out_vld_r, out_vld_nxt;
  bsm_pkg::out_rsp_t out_rsp_r, out_rsp_nxt;

  logic out_free, s1_move, in_acc;

  assign out_free = !out_vld_r || !out_stall;
  assign s1_move  = s1_vld_r && out_free;
  assign in_stall = s1_vld_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  // Decode
  logic [15:0] adr;
  logic reg_hit, adr_win;
  logic [bsm_pkg::WIN_IDX_W-1:0] reg_idx, win_idx, rd_idx;
  logic [8:0] entry;
  logic [7:0] bank;
  logic win_ok, in_range;
  logic [19:0] pos;
  bsm_pkg::bank_wr_t bank_wr;
  logic ram_en, ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0] ram_wdata, ram_q;

  assign adr     = in_req.bus_address;
  assign reg_idx = adr[3:0] - bsm_pkg::NIB_BASE;
  assign win_idx = adr[15:12] - bsm_pkg::NIB_BASE;
  assign adr_win = adr >= bsm_pkg::WIN_BASE;
  assign reg_hit = (adr >= bsm_pkg::REG_UPPER && adr <= bsm_pkg::REG_LAST) ||
                   (disk_mode_r && (adr == bsm_pkg::REG_BASE ||
                                    adr == bsm_pkg::REG_BASE + 16'd1));
  // One lookup per request: register index wins, else the window.
  assign rd_idx   = reg_hit ? reg_idx : win_idx;
  assign bank     = entry[7:0];
  assign win_ok   = adr_win && entry[8];
  assign in_range = ({1'b0, bank} < bank_count_r) && ({1'b0, bank} < BANK_LIMIT);
  assign pos      = {bank, adr[11:0]};

  always_comb begin
    bank_wr        = '0;
    ram_en         = 1'b0;
    ram_we         = 1'b0;
    ram_addr       = pos[AW-1:0];
    ram_wdata      = in_req.data_byte;
    s1_handled_nxt = 1'b0;
    s1_use_ram_nxt = 1'b0;
    s1_rd_nxt      = '0;
    case (in_req.op)
      bsm_pkg::OP_READ: begin
        if (reg_hit) begin
          s1_handled_nxt = 1'b1;
          s1_rd_nxt      = entry[8] ? bank : bsm_pkg::BYTE_OPEN;
        end else if (win_ok && (adr >= bsm_pkg::ROM_BASE || disk_mode_r)) begin
          s1_handled_nxt = 1'b1;
          s1_use_ram_nxt = in_range;
          ram_en         = in_acc && in_range;
        end
      end
      bsm_pkg::OP_WRITE: begin
        if (reg_hit) begin
          s1_handled_nxt = 1'b1;
          bank_wr.we     = in_acc;
          bank_wr.idx    = reg_idx;
          bank_wr.data   = in_req.data_byte;
        end else if (disk_mode_r && win_ok && adr < bsm_pkg::WR_LIMIT) begin
          s1_handled_nxt = 1'b1;
          ram_en         = in_acc && in_range;  // out-of-range bank drops
          ram_we         = 1'b1;
        end
      end
      bsm_pkg::OP_LOAD: begin
        ram_addr = in_req.image_address[AW-1:0];
        ram_we   = 1'b1;
        // bytes past the last addressable bank can never be read back
        ram_en   = in_acc && ({1'b0, in_req.image_address} < LOAD_LIMIT);
      end
      bsm_pkg::OP_RESTART: begin
        bank_wr.restart = in_acc;
      end
      default: ;
    endcase
  end

  bsm_bank_regs u_bank_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .bank_wr    (bank_wr),
    .dflt_upper (dflt_upper_r),
    .dflt_lower (dflt_lower_r),
    .dflt_valid (dflt_valid_r),
    .rd_idx     (rd_idx),
    .rd_entry   (entry)
  );

  bsm_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_image_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_q)
  );

  // Stage and output register next values
  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_acc) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_move) begin
      s1_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    out_rsp_nxt = out_rsp_r;
    if (s1_move) begin
      out_vld_nxt           = 1'b1;
      out_rsp_nxt.handled   = s1_handled_r;
      out_rsp_nxt.read_data = s1_use_ram_r ? ram_q : s1_rd_r;
    end else if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_handled_r <= s1_handled_nxt;
      s1_use_ram_r <= s1_use_ram_nxt;
      s1_rd_r      <= s1_rd_nxt;
    end
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_rsp   = out_rsp_r;

  // Checks
  `BSM_ASSERT_NEXT(a_acc_fills_s1, in_acc, s1_vld_r, "accepted request lost")
  `BSM_ASSERT_NEXT(a_move_fills_out, s1_move, out_vld_r, "result not registered")
  `BSM_ASSERT_NOW(a_unhandled_zero, out_vld_r && !out_rsp_r.handled, out_rsp_r.read_data == 8'd0, "unhandled result has data")
  `BSM_ASSERT_NOW(a_ram_on_accept, ram_en, in_acc, "memory access without request")

endmodule
`default_nettype wire
